// ===== src/rc6_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rc6_pkg;

  localparam int unsigned ROUNDS_DEF = 20;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KEY_PARTS  = 4;
  localparam int unsigned KPW        = $clog2(KEY_PARTS);
  localparam int unsigned KEY_WORDS  = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [WORD_W-1:0] P32 = 32'hB7E15163;
  localparam logic [WORD_W-1:0] Q32 = 32'h9E3779B9;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } blk_t;

  // Control from the key expander to the subkey store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic done;
  } kx_ctl_t;

  function automatic word_t rotl(word_t x, logic [4:0] s);
    return (x << s) | (x >> (6'd32 - {1'b0, s}));
  endfunction

  // Quadratic mixing function of one RC6 round: rotl(x * (2x + 1), 5).
  function automatic word_t rc6_f(word_t x);
    word_t p;
    p = x * ((x << 1) | 32'd1);
    return rotl(p, 5'd5);
  endfunction

endpackage

`default_nettype wire

// ===== src/rc6_block_encrypt.sv =====
// RC6-32/ROUNDS/32 encryption, one 128-bit block per request, blocks independent (ECB).
// The round engine works on one block at a time, one round per cycle, and takes the next
// block only once the last result has entered the output register.
// Key expansion runs after reset and after each key write; no block starts until it is done.
// Synchronous active-low reset clears the key to zero and empties the queue and output.
`timescale 1ns / 1ps
`default_nettype none

module rc6_block_encrypt #(
  parameter int unsigned ROUNDS = rc6_pkg::ROUNDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_plain_a,
  input  logic [31:0]                    in_plain_b,
  input  logic [31:0]                    in_plain_c,
  input  logic [31:0]                    in_plain_d,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_cipher_a,
  output logic [31:0]                    out_cipher_b,
  output logic [31:0]                    out_cipher_c,
  output logic [31:0]                    out_cipher_d,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rc6_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc6_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rc6_pkg::*;

  localparam int unsigned TBL = 2 * ROUNDS + 4;
  localparam int unsigned AW  = $clog2(TBL);

  // The front queue takes requests while the back end is busy with a block
  // or while its result waits in the output register.
  blk_t          in_blk;
  blk_t          q_blk;
  blk_t          out_blk;
  logic          q_valid;
  logic          q_pop;
  logic          back_busy;
  kx_ctl_t       kx_ctl;
  logic [AW-1:0] kx_wr_addr;
  logic [AW-1:0] kx_rd_addr;
  word_t         kx_wr_data;
  word_t         kx_rd_data;

  assign in_blk.a = in_plain_a;
  assign in_blk.b = in_plain_b;
  assign in_blk.c = in_plain_c;
  assign in_blk.d = in_plain_d;

  rc6_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_blk    (in_blk),
    .blk_valid (q_valid),
    .blk_pop   (q_pop),
    .blk       (q_blk)
  );

  // The key registers live in the expander. A write to an index past the last
  // key register is taken and ignored.
  rc6_keyexp #(
    .ROUNDS (ROUNDS)
  ) u_keyexp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .back_busy  (back_busy),
    .kx_ctl     (kx_ctl),
    .kx_wr_addr (kx_wr_addr),
    .kx_wr_data (kx_wr_data),
    .kx_rd_addr (kx_rd_addr),
    .kx_rd_data (kx_rd_data)
  );

  // The back end owns the subkey table, the round engine and the output register.
  rc6_back #(
    .ROUNDS (ROUNDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .blk_valid  (q_valid),
    .blk_pop    (q_pop),
    .blk        (q_blk),
    .back_busy  (back_busy),
    .kx_ctl     (kx_ctl),
    .kx_wr_addr (kx_wr_addr),
    .kx_wr_data (kx_wr_data),
    .kx_rd_addr (kx_rd_addr),
    .kx_rd_data (kx_rd_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_blk    (out_blk)
  );

  assign out_cipher_a = out_blk.a;
  assign out_cipher_b = out_blk.b;
  assign out_cipher_c = out_blk.c;
  assign out_cipher_d = out_blk.d;

endmodule

`default_nettype wire

// ===== src/rc6_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rc6_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rc6_pkg::blk_t in_blk,
  output logic          blk_valid,
  input  logic          blk_pop,
  output rc6_pkg::blk_t blk
);
  import rc6_pkg::*;

  localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW  = $clog2(QDEPTH + 1);

  blk_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           push;
  logic           pop;

  assign in_stall  = (cnt_r == CW'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign blk_valid = (cnt_r != '0);
  assign pop       = blk_pop && blk_valid;
  assign blk       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : QAW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : QAW'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        cnt_r <= CW'(cnt_r + 1'b1);
      end else if (pop && !push) begin
        cnt_r <= CW'(cnt_r - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rc6_keyexp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rc6_keyexp #(
  parameter  int unsigned ROUNDS = rc6_pkg::ROUNDS_DEF,
  localparam int unsigned TBL    = 2 * ROUNDS + 4,
  localparam int unsigned AW     = $clog2(TBL)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rc6_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rc6_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            back_busy,
  output rc6_pkg::kx_ctl_t                kx_ctl,
  output logic [AW-1:0]                   kx_wr_addr,
  output rc6_pkg::word_t                  kx_wr_data,
  output logic [AW-1:0]                   kx_rd_addr,
  input  rc6_pkg::word_t                  kx_rd_data
);
  import rc6_pkg::*;

  localparam int unsigned MIX = 3 * ((TBL > KEY_WORDS) ? TBL : KEY_WORDS);
  localparam int unsigned KW  = $clog2(MIX);

  typedef enum logic {KX_IDLE, KX_RUN} kx_state_t;

  kx_state_t             state_r;
  logic [CFG_DATA_W-1:0] key_r [KEY_PARTS];
  word_t                 lw_r [KEY_WORDS];
  word_t                 seed_r;
  word_t                 a_r;
  word_t                 b_r;
  logic [AW-1:0]         i_r;
  logic [KW-1:0]         k_r;
  logic                  lap0_r;
  logic                  expanded_r;
  logic                  cfg_hit;
  logic                  last_i;
  word_t                 s_cur;
  word_t                 a_nxt;
  word_t                 b_nxt;
  logic [4:0]            b_sh;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index < CFG_IDX_W'(KEY_PARTS));
  assign last_i    = (i_r == AW'(TBL - 1));

  // During the first lap over the table the entry still holds its seed value,
  // which is generated here; later laps read back what the earlier lap wrote.
  always_comb begin
    s_cur = lap0_r ? seed_r : kx_rd_data;
    a_nxt = rotl(s_cur + a_r + b_r, 5'd3);
    b_sh  = a_nxt[4:0] + b_r[4:0];
    b_nxt = rotl(lw_r[0] + a_nxt + b_r, b_sh);
  end

  assign kx_ctl.wr_en = (state_r == KX_RUN);
  assign kx_ctl.rd_en = (state_r == KX_RUN);
  assign kx_ctl.done  = expanded_r;
  assign kx_wr_addr   = i_r;
  assign kx_wr_data   = a_nxt;
  assign kx_rd_addr   = last_i ? '0 : AW'(i_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= KX_IDLE;
      expanded_r <= 1'b0;
      for (int p = 0; p < KEY_PARTS; p++) begin
        key_r[p] <= '0;
      end
    end else begin
      case (state_r)
        KX_IDLE: begin
          if (!expanded_r && !back_busy) begin
            for (int p = 0; p < KEY_PARTS; p++) begin
              lw_r[2*p]   <= key_r[p][WORD_W-1:0];
              lw_r[2*p+1] <= key_r[p][2*WORD_W-1:WORD_W];
            end
            seed_r  <= P32;
            a_r     <= '0;
            b_r     <= '0;
            i_r     <= '0;
            k_r     <= '0;
            lap0_r  <= 1'b1;
            state_r <= KX_RUN;
          end
        end
        KX_RUN: begin
          a_r <= a_nxt;
          b_r <= b_nxt;
          // Key words rotate through a shift line, so the current one is always at the head.
          for (int q = 0; q < KEY_WORDS - 1; q++) begin
            lw_r[q] <= lw_r[q+1];
          end
          lw_r[KEY_WORDS-1] <= b_nxt;
          seed_r <= seed_r + Q32;
          if (last_i) begin
            i_r    <= '0;
            lap0_r <= 1'b0;
          end else begin
            i_r <= AW'(i_r + 1'b1);
          end
          k_r <= KW'(k_r + 1'b1);
          if (k_r == KW'(MIX - 1)) begin
            expanded_r <= 1'b1;
            state_r    <= KX_IDLE;
          end
        end
        default: begin
          state_r <= KX_IDLE;
        end
      endcase
      // A key write abandons any expansion under way; it restarts from the new key.
      if (cfg_hit) begin
        key_r[cfg_index[KPW-1:0]] <= cfg_data;
        expanded_r                <= 1'b0;
        state_r                   <= KX_IDLE;
      end
    end
  end

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> !expanded_r && (state_r == KX_IDLE))
    else $error("key write did not restart key expansion");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == KX_RUN && k_r == KW'(MIX - 1) && !cfg_hit) |=> expanded_r)
    else $error("key expansion did not complete after its last pass");

  a_run_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == KX_RUN) |-> !expanded_r)
    else $error("subkey table reported ready while expansion is running");

endmodule

`default_nettype wire

// ===== src/rc6_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rc6_back #(
  parameter  int unsigned ROUNDS = rc6_pkg::ROUNDS_DEF,
  localparam int unsigned TBL    = 2 * ROUNDS + 4,
  localparam int unsigned AW     = $clog2(TBL)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             blk_valid,
  output logic             blk_pop,
  input  rc6_pkg::blk_t    blk,
  output logic             back_busy,
  input  rc6_pkg::kx_ctl_t kx_ctl,
  input  logic [AW-1:0]    kx_wr_addr,
  input  rc6_pkg::word_t   kx_wr_data,
  input  logic [AW-1:0]    kx_rd_addr,
  output rc6_pkg::word_t   kx_rd_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rc6_pkg::blk_t    out_blk
);
  import rc6_pkg::*;

  localparam int unsigned RW = $clog2(ROUNDS + 1);

  typedef enum logic [1:0] {BK_IDLE, BK_LOAD, BK_ROUND, BK_FINAL} bk_state_t;

  word_t         subkey_mem_r [TBL];
  word_t         rd0_r;
  word_t         rd1_r;
  logic [AW-1:0] raddr0;
  logic [AW-1:0] raddr1;

  bk_state_t     state_r;
  logic [AW-1:0] ptr_r;
  logic [RW-1:0] rnd_r;
  word_t         wa_r;
  word_t         wb_r;
  word_t         wc_r;
  word_t         wd_r;
  logic          out_valid_r;
  blk_t          out_blk_r;
  logic          out_free;
  logic          last_rnd;
  word_t         t;
  word_t         u;
  word_t         a_rnd;
  word_t         c_rnd;

  // Port 0 is lent to the key expander while it runs; the block engine is idle then.
  assign raddr0 = kx_ctl.rd_en ? kx_rd_addr : ptr_r;
  assign raddr1 = ptr_r | AW'(1);

  always_ff @(posedge clk) begin
    if (kx_ctl.wr_en) begin
      subkey_mem_r[kx_wr_addr] <= kx_wr_data;
    end
    rd0_r <= subkey_mem_r[raddr0];
    rd1_r <= subkey_mem_r[raddr1];
  end

  assign kx_rd_data = rd0_r;

  always_comb begin
    t     = rc6_f(wb_r);
    u     = rc6_f(wd_r);
    a_rnd = rotl(wa_r ^ t, u[4:0]) + rd0_r;
    c_rnd = rotl(wc_r ^ u, t[4:0]) + rd1_r;
  end

  assign blk_pop   = (state_r == BK_IDLE) && blk_valid && kx_ctl.done;
  assign back_busy = (state_r != BK_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign last_rnd  = (rnd_r == RW'(ROUNDS));
  assign out_valid = out_valid_r;
  assign out_blk   = out_blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      ptr_r       <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In the final state the output register is refilled in the same cycle instead.
      if (out_valid_r && !out_stall && (state_r != BK_FINAL)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        BK_IDLE: begin
          // The pair for pre-whitening is being read this cycle.
          if (blk_pop) begin
            wa_r    <= blk.a;
            wb_r    <= blk.b;
            wc_r    <= blk.c;
            wd_r    <= blk.d;
            ptr_r   <= AW'(ptr_r + AW'(2));
            state_r <= BK_LOAD;
          end
        end
        BK_LOAD: begin
          wb_r    <= wb_r + rd0_r;
          wd_r    <= wd_r + rd1_r;
          ptr_r   <= AW'(ptr_r + AW'(2));
          rnd_r   <= RW'(1);
          state_r <= BK_ROUND;
        end
        BK_ROUND: begin
          wa_r <= wb_r;
          wb_r <= c_rnd;
          wc_r <= wd_r;
          wd_r <= a_rnd;
          rnd_r <= RW'(rnd_r + 1'b1);
          // On the last round the pointer stays on the post-whitening pair,
          // so its read data holds steady while the result waits.
          if (last_rnd) begin
            state_r <= BK_FINAL;
          end else begin
            ptr_r <= AW'(ptr_r + AW'(2));
          end
        end
        BK_FINAL: begin
          if (out_free) begin
            out_blk_r.a <= wa_r + rd0_r;
            out_blk_r.b <= wb_r;
            out_blk_r.c <= wc_r + rd1_r;
            out_blk_r.d <= wd_r;
            out_valid_r <= 1'b1;
            ptr_r       <= '0;
            state_r     <= BK_IDLE;
          end
        end
        default: begin
          state_r <= BK_IDLE;
        end
      endcase
    end
  end

  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    kx_ctl.wr_en |-> (state_r == BK_IDLE))
    else $error("subkey table written while a block is in flight");

  a_pop_key: assert property (@(posedge clk) disable iff (!rst_n)
    blk_pop |-> kx_ctl.done)
    else $error("block started before key expansion completed");

  a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_ROUND && last_rnd) |=> (state_r == BK_FINAL))
    else $error("round sequence did not end after the last round");

endmodule

`default_nettype wire

// ===== verif/rc6_block_encrypt_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the RC6-32/20/32 block encryptor.
//
// Plaintext requests go in on the in_ channel and ciphertext comes back on the
// out_ channel. The 256-bit key is loaded through the cfg_ write channel as
// four 64-bit parts. The bench holds its own RC6 model, which expands the key
// lazily on the first block after a key change (the block itself expands it
// after each key write) and computes the ciphertext for every accepted
// plaintext request that has no typed-in one. Expectations wait in a queue
// and are matched in order against returned results, one field at a time.
//
// The run has two parts. A short scripted part comes first. It covers the
// all-zero key right after reset, with the published ciphertext typed in, and
// writes to unused register indexes that must leave the key alone. It also
// covers the published non-zero key, all-ones and mixed keys, and plaintext
// extremes. After that come random phases. Each phase may change the key and
// then streams random blocks. Both sides pause at random, and some phases run
// at full rate.
module rc6_block_encrypt_tb;

  localparam int ROUNDS_N      = 20;
  localparam int SUBKEYS_N     = 2 * ROUNDS_N + 4;
  localparam int KEY_WORDS_N   = 8;
  localparam int MIX_PASSES_N  = 3 * ((SUBKEYS_N > KEY_WORDS_N) ? SUBKEYS_N : KEY_WORDS_N);
  localparam int RANDOM_BLOCKS = 1300;
  localparam int MAX_WAIT      = 13;
  localparam int PRINT_CAP     = 60;
  // The longest legitimate quiet stretch is a full key expansion followed by a
  // block's latency, with both sides at their longest pause. This limit is many
  // times that stretch.
  localparam int QUIET_LIMIT   = 4000;

  // RC6 magic constants for 32-bit words.
  localparam logic [31:0] MAGIC_P = 32'hB7E15163;
  localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

  typedef logic [31:0] word_t;
  typedef logic [rc6_pkg::CFG_IDX_W-1:0] reg_index_t;
  typedef logic [rc6_pkg::CFG_DATA_W-1:0] key_part_t;

  // Register map of the key port. Any index above the last key part is unused.
  localparam reg_index_t KEY_PART_0       = reg_index_t'(0);
  localparam reg_index_t KEY_PART_1       = reg_index_t'(1);
  localparam reg_index_t KEY_PART_2       = reg_index_t'(2);
  localparam reg_index_t KEY_PART_3       = reg_index_t'(3);
  localparam reg_index_t IDX_FIRST_UNUSED = reg_index_t'(4);
  localparam reg_index_t IDX_LAST         = 8'hFF;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } block_t;

  // This is one line of the scripted part. It is either a key register write
  // or a plaintext block, and a block may carry a typed-in ciphertext.
  typedef struct packed {
    logic       is_key;
    reg_index_t idx;
    key_part_t  value;
    block_t     plain;
    logic       typed;
    block_t     cipher;
  } script_row_t;

  // These are the ways a random phase may change the key before it streams
  // blocks.
  typedef enum int {KEEP_KEY, ONE_PART, FRESH_KEY, EXTREME_KEY} key_plan_e;

  // This is the published ciphertext of the all-zero block under the all-zero
  // 256-bit key, in little-endian words.
  localparam block_t ZERO_KEY_CIPHER =
    {32'h05BD5F8F, 32'hA85FD110, 32'hDA3FFA93, 32'hC27E856E};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  wire        in_stall;
  word_t      in_plain_a = '0;
  word_t      in_plain_b = '0;
  word_t      in_plain_c = '0;
  word_t      in_plain_d = '0;
  wire        out_valid;
  logic       out_stall = 1'b0;
  wire [31:0] out_cipher_a;
  wire [31:0] out_cipher_b;
  wire [31:0] out_cipher_c;
  wire [31:0] out_cipher_d;
  logic       cfg_valid = 1'b0;
  wire        cfg_ready;
  reg_index_t cfg_index = '0;
  key_part_t  cfg_data = '0;

  rc6_block_encrypt #(
    .ROUNDS (ROUNDS_N)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_plain_a   (in_plain_a),
    .in_plain_b   (in_plain_b),
    .in_plain_c   (in_plain_c),
    .in_plain_d   (in_plain_d),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_cipher_a (out_cipher_a),
    .out_cipher_b (out_cipher_b),
    .out_cipher_c (out_cipher_c),
    .out_cipher_d (out_cipher_d),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // This is the model's copy of the key registers and of the subkey table.
  // The table is rebuilt on the first block after any accepted write to a
  // real key part.
  key_part_t key_shadow [4] = '{default: '0};
  word_t     subkeys [SUBKEYS_N];
  logic      schedule_fresh = 1'b0;

  // These are the ciphertexts still owed by the block, oldest first.
  block_t      pending_cipher [$];
  script_row_t script [$];

  // When set, both sides run without pauses.
  logic no_idle = 1'b0;

  int error_count  = 0;
  int n_results    = 0;
  int n_blocks     = 0;
  int n_directed   = 0;
  int n_key_writes = 0;
  int n_key_plans  = 0;
  int n_pauses     = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;

  function automatic word_t rol32(word_t x, logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  // This is the RC6 key schedule. It seeds the table from P and Q, then does
  // 3 * max(table, key words) mixing passes.
  function automatic void expand_schedule();
    word_t lw [KEY_WORDS_N];
    word_t a;
    word_t b;
    word_t sum;
    int    i;
    int    j;
    int    k;
    for (k = 0; k < 4; k++) begin
      lw[2 * k]     = key_shadow[k][31:0];
      lw[2 * k + 1] = key_shadow[k][63:32];
    end
    subkeys[0] = MAGIC_P;
    for (k = 1; k < SUBKEYS_N; k++)
      subkeys[k] = subkeys[k - 1] + MAGIC_Q;
    a = '0;
    b = '0;
    i = 0;
    j = 0;
    for (k = 0; k < MIX_PASSES_N; k++) begin
      subkeys[i] = rol32(subkeys[i] + a + b, 5'd3);
      a = subkeys[i];
      sum = a + b;
      lw[j] = rol32(lw[j] + sum, sum[4:0]);
      b = lw[j];
      i = (i + 1) % SUBKEYS_N;
      j = (j + 1) % KEY_WORDS_N;
    end
  endfunction

  function automatic block_t encrypt_block(block_t p);
    word_t  a;
    word_t  b;
    word_t  c;
    word_t  d;
    word_t  t;
    word_t  u;
    word_t  tmp;
    block_t r;
    int     i;
    if (!schedule_fresh) begin
      expand_schedule();
      schedule_fresh = 1'b1;
    end
    a = p.a;
    b = p.b + subkeys[0];
    c = p.c;
    d = p.d + subkeys[1];
    for (i = 1; i <= ROUNDS_N; i++) begin
      t = rol32(b * ((b << 1) + 32'd1), 5'd5);
      u = rol32(d * ((d << 1) + 32'd1), 5'd5);
      // Only the low five bits of t and u set the data-dependent rotations.
      a = rol32(a ^ t, u[4:0]) + subkeys[2 * i];
      c = rol32(c ^ u, t[4:0]) + subkeys[2 * i + 1];
      tmp = a;
      a = b;
      b = c;
      c = d;
      d = tmp;
    end
    a = a + subkeys[2 * ROUNDS_N + 2];
    c = c + subkeys[2 * ROUNDS_N + 3];
    r = {a, b, c, d};
    return r;
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // Plaintext words are mostly uniform, with zero, all ones, single set bits
  // and single clear bits mixed in.
  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w = word_t'(1) << $urandom_range(0, 31);
      3: w = ~(word_t'(1) << $urandom_range(0, 31));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic void add_block(block_t p, logic typed, block_t c);
    script_row_t row;
    row = '0;
    row.plain = p;
    row.typed = typed;
    row.cipher = c;
    script.push_back(row);
  endfunction

  function automatic void add_key(reg_index_t idx, key_part_t value);
    script_row_t row;
    row = '0;
    row.is_key = 1'b1;
    row.idx = idx;
    row.value = value;
    script.push_back(row);
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("%t result %0d: %s got %08h expected %08h",
               $realtime, n_results, what, got, want);
  endtask

  // This task offers one plaintext request after a random pause. The valid
  // signal stays high across back-to-back requests, so it is lowered only when
  // a pause actually follows.
  task automatic send_block(block_t p, logic typed, block_t c);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_plain_a <= p.a;
    in_plain_b <= p.b;
    in_plain_c <= p.c;
    in_plain_d <= p.d;
    do @(posedge clk); while (in_stall);
    pending_cipher.push_back(typed ? c : encrypt_block(p));
    n_blocks++;
  endtask

  // This task drops the request and waits until every owed ciphertext has come
  // back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cipher.size() != 0);
  endtask

  // This task writes one key register. A burst of writes keeps cfg_valid high
  // until its last write.
  task automatic put_key(reg_index_t idx, key_part_t value, logic last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    // A write to an unused index is dropped and leaves the expanded key valid.
    if (idx <= KEY_PART_3) begin
      key_shadow[idx[1:0]] = value;
      schedule_fresh = 1'b0;
    end
    n_key_writes++;
    if (last)
      cfg_valid <= 1'b0;
  endtask

  // This block checks each returned ciphertext against the oldest expectation.
  always @(posedge clk) begin : cipher_check
    block_t got;
    block_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_cipher_a, out_cipher_b, out_cipher_c, out_cipher_d};
      if (pending_cipher.size() == 0) begin
        report_mismatch("ciphertext with no block outstanding", got.a, '0);
      end else begin
        want = pending_cipher.pop_front();
        if (got.a !== want.a) report_mismatch("cipher_a", got.a, want.a);
        if (got.b !== want.b) report_mismatch("cipher_b", got.b, want.b);
        if (got.c !== want.c) report_mismatch("cipher_c", got.c, want.c);
        if (got.d !== want.d) report_mismatch("cipher_d", got.d, want.d);
      end
      n_results++;
    end
  end

  // After taking each result, the receiver holds stall high for a random
  // number of cycles. These pauses can land on any phase of the round engine
  // and can overlap key expansion.
  always @(posedge clk) begin : sink_pacing
    int n;
    if (out_valid && !out_stall) begin
      n = draw_wait();
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // The watchdog restarts its count on any handshake. Too long a silence means
  // the block has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("%t timeout: no handshake for %0d cycles, %0d blocks owed",
                 $realtime, QUIET_LIMIT, pending_cipher.size());
        $display("rc6_block_encrypt_tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int        k;
    int        n;
    int        phase;
    int        phase_len;
    int        pause_at;
    int        n_random;
    key_plan_e plan;
    logic      last;

    // No key has been written yet, so the all-zero key is expanded and used.
    add_block('0, 1'b1, ZERO_KEY_CIPHER);
    add_block('1, 1'b0, '0);
    add_block({4{32'h80000000}}, 1'b0, '0);
    add_block({4{32'h00000001}}, 1'b0, '0);
    add_block({32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555}, 1'b0, '0);
    add_block({32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000}, 1'b0, '0);
    add_block({32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF}, 1'b0, '0);
    // Writes to unused indexes must be ignored, so the zero-key answer stands.
    add_key(IDX_FIRST_UNUSED, '1);
    add_key(IDX_LAST, 64'h0123456789ABCDEF);
    add_block('0, 1'b1, ZERO_KEY_CIPHER);
    // This is the published non-zero 256-bit key and plaintext, as
    // little-endian words.
    add_key(KEY_PART_0, 64'hEFCDAB89_67452301);
    add_key(KEY_PART_1, 64'h78675645_34231201);
    add_key(KEY_PART_2, 64'hF0EFDECD_BCAB9A89);
    add_key(KEY_PART_3, 64'hFEDCBA98_76543210);
    add_block({32'h35241302, 32'h79685746, 32'hBDAC9B8A, 32'hF1E0DFCE}, 1'b0, '0);
    // All-ones key.
    add_key(KEY_PART_0, '1);
    add_key(KEY_PART_1, '1);
    add_key(KEY_PART_2, '1);
    add_key(KEY_PART_3, '1);
    add_block('0, 1'b0, '0);
    add_block('1, 1'b0, '0);
    // A single part changes, and the whole table must be rebuilt.
    add_key(KEY_PART_2, '0);
    add_block({32'h0000001F, 32'h00000020, 32'h0000001F, 32'h00000020}, 1'b0, '0);
    // When the key goes back to zero, the published answer must come back.
    add_key(KEY_PART_0, '0);
    add_key(KEY_PART_1, '0);
    add_key(KEY_PART_3, '0);
    add_block('0, 1'b1, ZERO_KEY_CIPHER);
    add_block('1, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Key writes happen only once every owed result is back.
    for (k = 0; k < script.size(); k++) begin
      if (script[k].is_key) begin
        if (k == 0 || !script[k - 1].is_key)
          wait_idle();
        last = (k == script.size() - 1) || !script[k + 1].is_key;
        put_key(script[k].idx, script[k].value, last);
      end else begin
        send_block(script[k].plain, script[k].typed, script[k].cipher);
        n_directed++;
      end
    end

    // In the random phases, each phase may change the key and then streams
    // blocks. Phase 1 always drains the block partway through, and other
    // phases do so at random.
    n_random = 0;
    phase = 0;
    while (n_random < RANDOM_BLOCKS) begin
      phase_len = $urandom_range(60, 140);
      // The last phase is cut short so the total stays at the planned count.
      if (phase_len > RANDOM_BLOCKS - n_random)
        phase_len = RANDOM_BLOCKS - n_random;
      pause_at = (phase == 1 || $urandom_range(0, 2) == 0) ?
                 int'($urandom_range(1, phase_len - 1)) : -1;
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0);
      plan = key_plan_e'($urandom_range(KEEP_KEY, EXTREME_KEY));
      if ($urandom_range(0, 3) == 0)
        put_key(reg_index_t'($urandom_range(IDX_FIRST_UNUSED, IDX_LAST)),
                {$urandom, $urandom}, plan == KEEP_KEY);
      case (plan)
        KEEP_KEY: begin
        end
        ONE_PART: begin
          put_key(reg_index_t'($urandom_range(KEY_PART_0, KEY_PART_3)),
                  {pick_word(), pick_word()}, 1'b1);
        end
        FRESH_KEY: begin
          for (k = KEY_PART_0; k <= KEY_PART_3; k++)
            put_key(reg_index_t'(k), {pick_word(), pick_word()}, k == KEY_PART_3);
        end
        EXTREME_KEY: begin
          for (k = KEY_PART_0; k <= KEY_PART_3; k++)
            put_key(reg_index_t'(k), $urandom_range(0, 1) ? '1 : '0, k == KEY_PART_3);
        end
      endcase
      if (plan != KEEP_KEY)
        n_key_plans++;
      for (n = 0; n < phase_len; n++) begin
        if (n == pause_at) begin
          wait_idle();
          n_pauses++;
        end
        send_block({pick_word(), pick_word(), pick_word(), pick_word()}, 1'b0, '0);
        n_random++;
      end
      phase++;
    end

    // Drain everything, then give the block time to show a stray result.
    wait_idle();
    repeat (ROUNDS_N + 8) @(posedge clk);

    $display("rc6_block_encrypt_tb: %0d blocks (%0d scripted) over %0d random phases",
             n_blocks, n_directed, phase);
    $display("rc6_block_encrypt_tb: %0d key writes, %0d key changes, %0d drains, %0d mismatches",
             n_key_writes, n_key_plans, n_pauses, error_count);
    if (error_count == 0) begin
      $display("rc6_block_encrypt_tb: done, clean");
    end else begin
      $display("rc6_block_encrypt_tb: done, errors");
    end
    $finish;
  end

endmodule
